// File: rtl/bpra_pkg.sv
package bpra_pkg;

  // Bitmap geometry
  localparam int unsigned MAP_WORDS = 1024;
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned WORD_AW   = $clog2(MAP_WORDS);
  localparam int unsigned BIT_AW    = $clog2(WORD_BITS);
  localparam int unsigned COUNT_W   = 7;

  typedef logic [WORD_BITS-1:0] word_t;

  // Result of the free-run search in one bitmap word
  typedef struct packed {
    logic              hit;
    logic [BIT_AW-1:0] pos;
  } run_find_t;

  // Mask of n low ones, all ones for n of a full word or more
  function automatic word_t run_mask(input logic [COUNT_W-1:0] n);
    word_t m;
    if (n >= COUNT_W'(WORD_BITS)) begin
      m = '1;
    end else begin
      m = (word_t'(1) << n) - word_t'(1);
    end
    return m;
  endfunction

endpackage

// File: rtl/bpra_ram.sv
module bpra_ram #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned WIDTH  = 64,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/bpra_run_find.sv
module bpra_run_find (
  input  bpra_pkg::word_t                   word,
  input  logic [bpra_pkg::COUNT_W-1:0]      count,
  output bpra_pkg::run_find_t               find
);

  bpra_pkg::word_t cand;
  bpra_pkg::word_t low_one;

  // Candidate start positions: run fits in the word and all bits are free
  always_comb begin
    bpra_pkg::word_t m;
    bpra_pkg::word_t shifted;
    m    = bpra_pkg::run_mask(count);
    cand = '0;
    for (int b = 0; b < int'(bpra_pkg::WORD_BITS); b++) begin
      shifted = word >> b;
      cand[b] = (count <= bpra_pkg::COUNT_W'(int'(bpra_pkg::WORD_BITS) - b)) &&
                ((shifted & m) == '0);
    end
  end

  // Isolate lowest candidate, then encode it
  assign low_one = cand & (~cand + bpra_pkg::word_t'(1));

  always_comb begin
    find.hit = |cand;
    find.pos = '0;
    for (int j = 0; j < int'(bpra_pkg::WORD_BITS); j++) begin
      if (low_one[j]) begin
        find.pos = find.pos | bpra_pkg::BIT_AW'(j);
      end
    end
  end

endmodule

// File: rtl/bitmap_page_run_allocator_top.sv
// Page bitmap run allocator: 1024 words of 64 pages, a set bit marks a used page.
// Request channel (in_valid/in_stall): mode 0 allocates run_pages pages as the
// lowest free run inside one word, scanning words first_word .. end_word-1 in
// order; mode 1 frees run_pages pages from first_page, clipped at its word end.
// Result channel (out_valid/out_stall): one result per request, ok and the first
// page of the allocated run in run_start (0 on failure and for frees).
// Config port: cfg_we writes first_word (index 0) or end_word (index 1); write
// only while no request is in flight.
// Timing: the bitmap sits in one RAM with a registered read, so a scan reads one
// word per cycle. After accept an allocation runs ST_SCAN, a free ST_FREE, and
// an immediately rejected request neither; each then waits in ST_FINISH until the
// output register is free and loads its result there. One request is in work at
// a time; in_stall is high from accept until the result enters the output
// register. A new request is taken while a finished result still waits.
// Reset: the RAM is cleared by a pass over all 1024 words, one word per cycle, with
// in_stall held high; config writes are still taken. A stalled result holds and
// the next finished request waits for the output register to empty.
module bitmap_page_run_allocator_top (
  input  logic        clk,
  input  logic        rst,
  // config port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [6:0]  run_pages,
  input  logic [15:0] first_page,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ok,
  output logic [15:0] run_start
);

  localparam int unsigned AW = bpra_pkg::WORD_AW;
  localparam int unsigned BW = bpra_pkg::BIT_AW;
  localparam int unsigned SW = AW + 1;

  localparam logic CFG_FIRST_WORD = 1'b0;
  localparam logic CFG_END_WORD   = 1'b1;

  localparam logic MODE_ALLOC = 1'b0;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_FREE   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]                  state;
  logic [AW-1:0]               clr_addr;
  logic [SW-1:0]               rd_addr;
  logic                        rd_pend;
  logic [AW-1:0]               rd_word;
  logic [AW-1:0]               free_word;
  logic [BW-1:0]               op_bit;
  logic [bpra_pkg::COUNT_W-1:0] op_count;
  logic                        res_ok;
  logic [15:0]                 res_idx;
  logic [AW-1:0]               first_word;
  logic [SW-1:0]               end_word;

  logic                        in_acc;
  logic                        out_free;
  logic [SW-1:0]               stop;
  logic                        issue;
  logic                        alloc_bad;
  logic                        scan_hit;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  bpra_pkg::word_t             ram_wdata;
  logic [AW-1:0]               ram_raddr;
  bpra_pkg::word_t             ram_rdata;
  bpra_pkg::run_find_t         find;

  // Bitmap store
  bpra_ram #(
    .DEPTH (bpra_pkg::MAP_WORDS),
    .WIDTH (bpra_pkg::WORD_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Run search on the word coming out of the RAM
  bpra_run_find u_find (
    .word  (ram_rdata),
    .count (op_count),
    .find  (find)
  );

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Scan window end, clipped to the store
  assign stop = (end_word > SW'(bpra_pkg::MAP_WORDS)) ? SW'(bpra_pkg::MAP_WORDS) : end_word;
  assign issue = (rd_addr < stop);
  assign alloc_bad = (run_pages == '0) ||
                     (run_pages > bpra_pkg::COUNT_W'(bpra_pkg::WORD_BITS)) ||
                     ({1'b0, first_word} >= stop);
  assign scan_hit = (state == ST_SCAN) && rd_pend && find.hit;

  // Read address: free word at accept, scan pointer otherwise
  assign ram_raddr = (state == ST_IDLE) ? first_page[15:BW] : rd_addr[AW-1:0];

  // Write port: clearing pass, allocation mark, free clear
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_word;
    ram_wdata = ram_rdata | (bpra_pkg::run_mask(op_count) << find.pos);
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      ST_SCAN: begin
        ram_we = scan_hit;
      end
      ST_FREE: begin
        ram_we    = 1'b1;
        ram_waddr = free_word;
        ram_wdata = ram_rdata & ~(bpra_pkg::run_mask(op_count) << op_bit);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_word <= '0;
      end_word   <= SW'(bpra_pkg::MAP_WORDS);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_WORD: first_word <= cfg_data[AW-1:0];
        CFG_END_WORD:   end_word   <= cfg_data;
        default:        first_word <= first_word;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Output register: load a finished result, else drop an accepted one
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(bpra_pkg::MAP_WORDS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            op_count  <= run_pages;
            op_bit    <= first_page[BW-1:0];
            free_word <= first_page[15:BW];
            rd_addr   <= {1'b0, first_word};
            rd_pend   <= 1'b0;
            res_idx   <= '0;
            if (mode == MODE_ALLOC) begin
              res_ok <= 1'b0;
              state  <= alloc_bad ? ST_FINISH : ST_SCAN;
            end else if (run_pages == '0) begin
              res_ok <= 1'b0;
              state  <= ST_FINISH;
            end else begin
              res_ok <= 1'b1;
              state  <= ST_FREE;
            end
          end
        end
        ST_SCAN: begin
          rd_pend <= issue;
          rd_word <= rd_addr[AW-1:0];
          if (issue) begin
            rd_addr <= rd_addr + SW'(1);
          end
          if (scan_hit) begin
            res_ok  <= 1'b1;
            res_idx <= {rd_word, find.pos};
            state   <= ST_FINISH;
          end else if (!issue && !rd_pend) begin
            state <= ST_FINISH;
          end
        end
        ST_FREE: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            ok        <= res_ok;
            run_start <= res_idx;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
